// ===== src/rbf_pkg.sv =====
// shared types, constants and tables of the rbf kernel sum evaluator
`default_nettype none
package rbf_pkg;

    // defaults of the top level parameters
    localparam int DEF_MAX_CENTERS = 64;
    localparam int DEF_MAX_DIMS    = 4;
    localparam int QUERY_COORDS    = 4;

    // field and datapath widths
    localparam int DATA_W  = 32;
    localparam int OUT_W   = 48;
    localparam int OP_W    = 2;
    localparam int CI_IN_W = 6;
    localparam int MI_IN_W = 2;
    localparam int CFG_W   = 2;
    localparam int D_W     = 50;
    localparam int T_W     = 22;
    localparam int P_W     = 31;
    localparam int K_W     = 17;
    localparam int ACC_W   = 64;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    // arithmetic constants
    localparam logic [T_W-1:0]   T_CAP      = T_W'(32'd2097152);
    localparam logic [T_W-1:0]   POLY_LIM   = T_W'(32'd262144);
    localparam logic [P_W-1:0]   ONE30      = P_W'(32'h4000_0000);
    localparam logic [3:0]       EXP_TERMS  = 4'd12;
    localparam logic [2:0]       EXP_SQUARE = 3'd5;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32'h8000);
    localparam logic signed [OUT_W-1:0] SUM_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SUM_LO = {1'b1, {(OUT_W-1){1'b0}}};

    // operation codes
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_CENTER = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_WEIGHT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_NUM_CENTERS = 2'd0;
    localparam logic [CFG_W-1:0] CFG_NUM_DIMS    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_KERNEL_SEL  = 2'd2;
    localparam logic [CFG_W-1:0] CFG_INV_LEN_SQ  = 2'd3;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_COORD,
        S_DIFF,
        S_SQ,
        S_ACCD,
        S_SCALE_HI,
        S_SCALE_LO,
        S_SCALE_T,
        S_POLY,
        S_POLY_K,
        S_EXP_FP,
        S_EXP_DIV,
        S_EXP_FIX,
        S_EXP_SQ,
        S_EXP_SQR,
        S_WMUL,
        S_ACC,
        S_ROUND,
        S_OUT
    } t_state;

    // reciprocal floor(2^32 / j) + 1, exact quotient after one correction
    function automatic logic [DATA_W-1:0] recip(input logic [3:0] j);
        logic [DATA_W-1:0] r;
        case (j)
            4'd2:    r = 32'd2147483649;
            4'd3:    r = 32'd1431655766;
            4'd4:    r = 32'd1073741825;
            4'd5:    r = 32'd858993460;
            4'd6:    r = 32'd715827883;
            4'd7:    r = 32'd613566757;
            4'd8:    r = 32'd536870913;
            4'd9:    r = 32'd477218589;
            4'd10:   r = 32'd429496730;
            4'd11:   r = 32'd390451573;
            4'd12:   r = 32'd357913942;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/rbf_store.sv =====
// center and weight memories, one write and one registered read port each
`default_nettype none
module rbf_store #(
    parameter int MAX_CENTERS = 64,
    parameter int MAX_DIMS    = 4,
    parameter int CA_W        = 8,
    parameter int CI_W        = 6
) (
    input  logic                       i_clk,
    input  logic                       i_c_we,
    input  logic [CA_W-1:0]            i_c_waddr,
    input  logic [rbf_pkg::DATA_W-1:0] i_c_wdata,
    input  logic                       i_c_re,
    input  logic [CA_W-1:0]            i_c_raddr,
    output logic [rbf_pkg::DATA_W-1:0] o_c_rdata,
    input  logic                       i_w_we,
    input  logic [CI_W-1:0]            i_w_waddr,
    input  logic [rbf_pkg::DATA_W-1:0] i_w_wdata,
    input  logic                       i_w_re,
    input  logic [CI_W-1:0]            i_w_raddr,
    output logic [rbf_pkg::DATA_W-1:0] o_w_rdata
);
    import rbf_pkg::*;

    logic [DATA_W-1:0] center_mem [MAX_CENTERS*MAX_DIMS];
    logic [DATA_W-1:0] weight_mem [MAX_CENTERS];
    logic [DATA_W-1:0] r_c_rdata;
    logic [DATA_W-1:0] r_w_rdata;

    // center coordinates
    always_ff @(posedge i_clk) begin
        if (i_c_we) begin
            center_mem[i_c_waddr] <= i_c_wdata;
        end
        if (i_c_re) begin
            r_c_rdata <= center_mem[i_c_raddr];
        end
    end

    // weights
    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            weight_mem[i_w_waddr] <= i_w_wdata;
        end
        if (i_w_re) begin
            r_w_rdata <= weight_mem[i_w_raddr];
        end
    end

    assign o_c_rdata = r_c_rdata;
    assign o_w_rdata = r_w_rdata;

endmodule
`default_nettype wire

// ===== src/rbf_mul.sv =====
// shared signed multiplier with a registered product
`default_nettype none
module rbf_mul (
    input  logic                              i_clk,
    input  logic signed [rbf_pkg::MUL_W-1:0]  i_a,
    input  logic signed [rbf_pkg::MUL_W-1:0]  i_b,
    output logic signed [rbf_pkg::PROD_W-1:0] o_p
);
    import rbf_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== src/rbf_kernel_sum_eval_unit.sv =====
// rbf kernel sum evaluator: sequencer, configuration and output register
//
// Input channel (i_in_valid / o_in_stall) carries load and query items.
// A center or weight write is taken and gives no result; the block stays
// ready. A query walks the active centers one after another,
// reading coordinates and weight from the stores and running the distance,
// scaling, kernel and weighted accumulation on one shared multiplier.
// The exponential kernel runs twelve Horner steps and five squarings on the
// shared multiplier; input stalls for the whole query.
// Output channel (o_out_valid / i_out_stall) holds one finished result in
// an output register; a new item is taken while it waits, and a query
// that ends while the receiver stalls waits until the register frees.
// Configuration writes (i_cfg_we) take effect at once and are to be made
// only while idle by the user; the block does not enforce this. Reset
// (synchronous, active low) clears the sequencer and output valid, sets the
// configuration defaults; the stores are undefined until written.
`default_nettype none
module rbf_kernel_sum_eval_unit #(
    parameter int MAX_CENTERS = rbf_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = rbf_pkg::DEF_MAX_DIMS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbf_pkg::CFG_W-1:0]        i_cfg_index,
    input  logic [rbf_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rbf_pkg::OP_W-1:0]         i_operation,
    input  logic [rbf_pkg::CI_IN_W-1:0]      i_center_index,
    input  logic [rbf_pkg::MI_IN_W-1:0]      i_coord_index,
    input  logic signed [rbf_pkg::DATA_W-1:0] i_write_value,
    input  logic signed [rbf_pkg::DATA_W-1:0] i_query_x0,
    input  logic signed [rbf_pkg::DATA_W-1:0] i_query_x1,
    input  logic signed [rbf_pkg::DATA_W-1:0] i_query_x2,
    input  logic signed [rbf_pkg::DATA_W-1:0] i_query_x3,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [rbf_pkg::OUT_W-1:0] o_interpolated_value,
    output logic                             o_saturated
);
    import rbf_pkg::*;

    localparam int CA_W  = (MAX_CENTERS * MAX_DIMS > 1) ? $clog2(MAX_CENTERS * MAX_DIMS) : 1;
    localparam int CI_W  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CENTERS + 1);
    localparam int DLIM  = (MAX_DIMS < QUERY_COORDS) ? MAX_DIMS : QUERY_COORDS;

    // configuration registers
    logic [6:0]        r_num_centers;
    logic [2:0]        r_num_dims;
    logic              r_kernel_sel;
    logic [DATA_W-1:0] r_inv_len_sq;

    // sequencer and datapath registers
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_ci;
    logic [2:0]               r_mi;
    logic signed [DATA_W-1:0] r_qx [QUERY_COORDS];
    logic [DATA_W-1:0]        r_a;
    logic [D_W-1:0]           r_d;
    logic [D_W-1:0]           r_hip;
    logic [T_W-1:0]           r_t;
    logic [P_W-1:0]           r_p;
    logic [P_W-1:0]           r_x;
    logic [3:0]               r_j;
    logic [2:0]               r_s;
    logic [K_W-1:0]           r_k;
    logic [ACC_W-1:0]         r_acc;
    logic signed [OUT_W-1:0]  r_res;
    logic                     r_res_sat;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_value;
    logic                     r_out_sat;

    // memory and multiplier connections
    logic                     c_we, w_we, mem_re;
    logic [CA_W-1:0]          c_waddr, c_raddr;
    logic [CI_W-1:0]          w_waddr;
    logic [DATA_W-1:0]        c_rdata, w_rdata;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // derived control values
    logic                     in_acc, out_take, out_free;
    logic [CNT_W-1:0]         n_active;
    logic [2:0]               dims;
    logic                     last_dim, last_center;
    logic signed [DATA_W:0]   diff;
    logic [48:0]              t_sum;
    logic [T_W-1:0]           t_next;
    logic [P_W-1:0]           x_cur, p_sq;
    logic [31:0]              q0, q_fix;
    logic [35:0]              qj;
    logic [18:0]              u_poly;
    logic [31:0]              k_round;
    logic [ACC_W-1:0]         acc_rnd;
    logic signed [ACC_W-1:0]  q_sum;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign n_active = CNT_W'((32'(r_num_centers) > MAX_CENTERS) ? MAX_CENTERS
                                                                : 32'(r_num_centers));
    assign dims     = 3'((32'(r_num_dims) > DLIM) ? DLIM : 32'(r_num_dims));
    assign last_dim    = (r_mi + 3'd1) >= dims;
    assign last_center = CNT_W'(r_ci + 1'b1) >= n_active;

    // store write side, straight from an accepted load item
    assign c_we    = in_acc && (i_operation == OP_WR_CENTER)
                     && (32'(i_center_index) < MAX_CENTERS)
                     && (32'(i_coord_index) < MAX_DIMS);
    assign w_we    = in_acc && (i_operation == OP_WR_WEIGHT)
                     && (32'(i_center_index) < MAX_CENTERS);
    assign c_waddr = CA_W'(32'(i_center_index) * MAX_DIMS + 32'(i_coord_index));
    assign w_waddr = CI_W'(i_center_index);
    assign c_raddr = CA_W'(32'(r_ci[CI_W-1:0]) * MAX_DIMS + 32'(r_mi));

    rbf_store #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS),
        .CA_W        (CA_W),
        .CI_W        (CI_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_c_we    (c_we),
        .i_c_waddr (c_waddr),
        .i_c_wdata (i_write_value),
        .i_c_re    (mem_re),
        .i_c_raddr (c_raddr),
        .o_c_rdata (c_rdata),
        .i_w_we    (w_we),
        .i_w_waddr (w_waddr),
        .i_w_wdata (i_write_value),
        .i_w_re    (mem_re),
        .i_w_raddr (r_ci[CI_W-1:0]),
        .o_w_rdata (w_rdata)
    );

    rbf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // datapath arithmetic between registers
    assign diff    = {c_rdata[DATA_W-1], c_rdata} - {r_qx[r_mi[1:0]][DATA_W-1], r_qx[r_mi[1:0]]};
    assign t_sum   = 49'({r_hip[20:0], 16'b0}) + 49'(prod[63:16]);
    assign t_next  = ((r_hip[D_W-1:21] != '0) || (t_sum > 49'(T_CAP))) ? T_CAP
                                                                         : t_sum[T_W-1:0];
    assign x_cur   = prod[60:30];
    assign q0      = prod[63:32];
    assign qj      = 36'(q0) * 36'(r_j);
    assign q_fix   = (qj > 36'(r_x)) ? (q0 - 32'd1) : q0;
    assign p_sq    = prod[60:30];
    assign k_round = (32'(p_sq) + 32'h2000) >> 14;
    assign u_poly  = 19'(POLY_LIM) - r_t[18:0];
    assign acc_rnd = r_acc + ROUND_HALF;
    assign q_sum   = $signed(acc_rnd) >>> 16;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation == OP_QUERY)) begin
                    n_state = (n_active == '0) ? S_ROUND : S_COORD;
                end
            end
            S_COORD:    n_state = (dims == 3'd0) ? S_SCALE_HI : S_DIFF;
            S_DIFF:     n_state = S_SQ;
            S_SQ:       n_state = S_ACCD;
            S_ACCD:     n_state = last_dim ? S_SCALE_HI : S_COORD;
            S_SCALE_HI: n_state = S_SCALE_LO;
            S_SCALE_LO: n_state = S_SCALE_T;
            S_SCALE_T:  n_state = r_kernel_sel ? S_EXP_FP : S_POLY;
            S_POLY:     n_state = (r_t >= POLY_LIM) ? S_WMUL : S_POLY_K;
            S_POLY_K:   n_state = S_WMUL;
            S_EXP_FP:   n_state = S_EXP_DIV;
            S_EXP_DIV:  n_state = (r_j == 4'd1) ? S_EXP_SQ : S_EXP_FIX;
            S_EXP_FIX:  n_state = S_EXP_FP;
            S_EXP_SQ:   n_state = S_EXP_SQR;
            S_EXP_SQR:  n_state = (r_s == 3'd1) ? S_WMUL : S_EXP_SQ;
            S_WMUL:     n_state = S_ACC;
            S_ACC:      n_state = last_center ? S_ROUND : S_COORD;
            S_ROUND:    n_state = S_OUT;
            S_OUT:      n_state = out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        mem_re     = (r_state == S_COORD);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_SQ: begin
                mul_a = {1'b0, r_a};
                mul_b = {1'b0, r_a};
            end
            S_SCALE_HI: begin
                mul_a = {15'b0, r_d[D_W-1:32]};
                mul_b = {1'b0, r_inv_len_sq};
            end
            S_SCALE_LO: begin
                mul_a = {1'b0, r_d[31:0]};
                mul_b = {1'b0, r_inv_len_sq};
            end
            S_POLY: begin
                mul_a = {14'b0, u_poly};
                mul_b = {14'b0, u_poly};
            end
            S_EXP_FP: begin
                mul_a = {2'b0, r_t, 9'b0};
                mul_b = {2'b0, r_p};
            end
            S_EXP_DIV: begin
                mul_a = {2'b0, x_cur};
                mul_b = {1'b0, recip(r_j)};
            end
            S_EXP_SQ: begin
                mul_a = {2'b0, r_p};
                mul_b = {2'b0, r_p};
            end
            S_WMUL: begin
                mul_a = {w_rdata[DATA_W-1], w_rdata};
                mul_b = {16'b0, r_k};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_num_centers <= 7'd0;
            r_num_dims    <= 3'd1;
            r_kernel_sel  <= 1'b1;
            r_inv_len_sq  <= 32'd65536;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_CENTERS: r_num_centers <= i_cfg_data[6:0];
                    CFG_NUM_DIMS:    r_num_dims    <= i_cfg_data[2:0];
                    CFG_KERNEL_SEL:  r_kernel_sel  <= i_cfg_data[0];
                    CFG_INV_LEN_SQ:  r_inv_len_sq  <= i_cfg_data;
                    default:         r_kernel_sel  <= r_kernel_sel;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation == OP_QUERY)) begin
                    r_qx[0] <= i_query_x0;
                    r_qx[1] <= i_query_x1;
                    r_qx[2] <= i_query_x2;
                    r_qx[3] <= i_query_x3;
                    r_ci    <= '0;
                    r_mi    <= 3'd0;
                    r_d     <= '0;
                    r_acc   <= '0;
                end
            end
            S_DIFF: begin
                r_a <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
            end
            S_ACCD: begin
                r_d  <= r_d + D_W'(prod[63:16]);
                r_mi <= r_mi + 3'd1;
            end
            S_SCALE_LO: begin
                r_hip <= prod[D_W-1:0];
            end
            S_SCALE_T: begin
                r_t <= t_next;
                r_p <= ONE30;
                r_j <= EXP_TERMS;
                r_s <= EXP_SQUARE;
            end
            S_POLY: begin
                r_k <= '0;
            end
            S_POLY_K: begin
                r_k <= prod[36:20];
            end
            S_EXP_DIV: begin
                r_x <= x_cur;
                if (r_j == 4'd1) begin
                    r_p <= ONE30 - x_cur;
                end
            end
            S_EXP_FIX: begin
                r_p <= ONE30 - q_fix[P_W-1:0];
                r_j <= r_j - 4'd1;
            end
            S_EXP_SQR: begin
                r_p <= p_sq;
                r_s <= r_s - 3'd1;
                r_k <= k_round[K_W-1:0];
            end
            S_ACC: begin
                r_acc <= r_acc + prod[ACC_W-1:0];
                r_ci  <= CNT_W'(r_ci + 1'b1);
                r_mi  <= 3'd0;
                r_d   <= '0;
            end
            S_ROUND: begin
                if (q_sum > ACC_W'(SUM_HI)) begin
                    r_res     <= SUM_HI;
                    r_res_sat <= 1'b1;
                end else if (q_sum < ACC_W'(SUM_LO)) begin
                    r_res     <= SUM_LO;
                    r_res_sat <= 1'b1;
                end else begin
                    r_res     <= q_sum[OUT_W-1:0];
                    r_res_sat <= 1'b0;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_value <= r_res;
                    r_out_sat   <= r_res_sat;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_interpolated_value = r_out_value;
    assign o_saturated          = r_out_sat;

endmodule
`default_nettype wire

// ===== src/rbf_checker.sv =====
// port level checks of the rbf kernel sum evaluator, bound to the top level
`default_nettype none
module rbf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [rbf_pkg::CFG_W-1:0]         i_cfg_index,
    input logic [rbf_pkg::DATA_W-1:0]        i_cfg_data,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [rbf_pkg::OP_W-1:0]          i_operation,
    input logic [rbf_pkg::CI_IN_W-1:0]       i_center_index,
    input logic [rbf_pkg::MI_IN_W-1:0]       i_coord_index,
    input logic signed [rbf_pkg::DATA_W-1:0] i_write_value,
    input logic signed [rbf_pkg::DATA_W-1:0] i_query_x0,
    input logic signed [rbf_pkg::DATA_W-1:0] i_query_x1,
    input logic signed [rbf_pkg::DATA_W-1:0] i_query_x2,
    input logic signed [rbf_pkg::DATA_W-1:0] i_query_x3,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [rbf_pkg::OUT_W-1:0]  o_interpolated_value,
    input logic                              o_saturated
);
    import rbf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_interpolated_value) && $stable(o_saturated))
        else $error("stalled result changed");

    // a clipped sum sits on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_interpolated_value == SUM_HI) || (o_interpolated_value == SUM_LO))
        else $error("saturated flag without limit value");

    // a load item leaves the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_operation != OP_QUERY) |=> !o_in_stall)
        else $error("block busy after load item");

    // a query item occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_operation == OP_QUERY) |=> o_in_stall)
        else $error("block ready right after query item");

endmodule

bind rbf_kernel_sum_eval_unit rbf_checker u_rbf_checker (.*);
`default_nettype wire
